FILE: src/cheapest_delta_chain_search_assert.svh
// Assertion macros used by the top-level RTL file.
`ifndef CHEAPEST_DELTA_CHAIN_SEARCH_ASSERT_SVH
`define CHEAPEST_DELTA_CHAIN_SEARCH_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define CDCS_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define CDCS_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: src/cdcs_pkg.sv
`default_nettype none

package cdcs_pkg;

    localparam int COST_BITS = 48;
    localparam logic [COST_BITS-1:0] COST_INF = {COST_BITS{1'b1}};

    localparam int S_DATA_BITS = 80;
    localparam int M_DATA_BITS = 56;
    localparam int SLOT_BITS = 5;
    localparam int OUTCOME_BITS = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic [OUTCOME_BITS-1:0] OUT_FOUND = 2'd0;
    localparam logic [OUTCOME_BITS-1:0] OUT_UNREACHABLE = 2'd1;
    localparam logic [OUTCOME_BITS-1:0] OUT_NO_MATCH = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_MARK,
        ST_RELAX,
        ST_FIND,
        ST_WALK_RD,
        ST_WALK_WAIT,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_OUT
    } state_t;

    function automatic logic [COST_BITS-1:0] sat_add(input logic [COST_BITS-1:0] a,
                                                     input logic [COST_BITS-1:0] b);
        logic [COST_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (a == COST_INF || b == COST_INF || sum >= {1'b0, COST_INF}) begin
            return COST_INF;
        end
        return sum[COST_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/cdcs_table.sv
`default_nettype none

module cdcs_table #(
    parameter int DEPTH = 32,
    parameter int IW = 5,
    parameter int VB = 16,
    parameter int CB = 48
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [IW-1:0] wr_addr,
    input  wire logic [VB-1:0] wr_src,
    input  wire logic [VB-1:0] wr_tgt,
    input  wire logic [CB-1:0] wr_cost,
    input  wire logic          wr_base,
    input  wire logic [IW-1:0] rd_addr,
    output logic      [VB-1:0] rd_src,
    output logic      [VB-1:0] rd_tgt,
    output logic      [CB-1:0] rd_cost,
    output logic               rd_base
);

    logic [VB-1:0] src_mem [DEPTH];
    logic [VB-1:0] tgt_mem [DEPTH];
    logic [CB-1:0] cost_mem [DEPTH];
    logic          base_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            src_mem[wr_addr] <= wr_src;
            tgt_mem[wr_addr] <= wr_tgt;
            cost_mem[wr_addr] <= wr_cost;
            base_mem[wr_addr] <= wr_base;
        end
        rd_src <= src_mem[rd_addr];
        rd_tgt <= tgt_mem[rd_addr];
        rd_cost <= cost_mem[rd_addr];
        rd_base <= base_mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: src/cdcs_state.sv
`default_nettype none

module cdcs_state #(
    parameter int DEPTH = 32,
    parameter int IW = 5,
    parameter int PW = 6,
    parameter int CB = 48
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [IW-1:0] wr_addr,
    input  wire logic          wr_done,
    input  wire logic [PW-1:0] wr_prev,
    input  wire logic [CB-1:0] wr_weight,
    input  wire logic [IW-1:0] rd_addr,
    output logic               rd_done,
    output logic      [PW-1:0] rd_prev,
    output logic      [CB-1:0] rd_weight
);

    logic          done_mem [DEPTH];
    logic [PW-1:0] prev_mem [DEPTH];
    logic [CB-1:0] weight_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            done_mem[wr_addr] <= wr_done;
            prev_mem[wr_addr] <= wr_prev;
            weight_mem[wr_addr] <= wr_weight;
        end
        rd_done <= done_mem[rd_addr];
        rd_prev <= prev_mem[rd_addr];
        rd_weight <= weight_mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: src/cheapest_delta_chain_search.sv
// A load beat is accepted in the idle state and the block is ready again in the next cycle.
// A search makes read-modify-write passes over the weight memory, one entry a cycle: an init
// pass, then a scan, a mark and a relax pass for each delta settled, a last scan and a find pass.
// The chain walk then follows each delta's predecessor back to the start of the chain, and each
// result beat is read from the stack, loaded and then held through any output stall.
// Reset (synchronous, active low) empties the table, clears the result valid and leaves input ready.
`default_nettype none
`include "cheapest_delta_chain_search_assert.svh"

module cheapest_delta_chain_search #(
    parameter int MAX_DELTAS = 32,
    parameter int VERSION_BITS = 16,
    parameter int SIZE_BITS = 40
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // from_version, to_version, delta_bytes, already_cached, base_available, zero fill
    input  wire logic [cdcs_pkg::S_DATA_BITS-1:0]    s_tdata,
    // command
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // delta_slot, chain_cost, zero fill
    output logic      [cdcs_pkg::M_DATA_BITS-1:0]    m_tdata,
    // outcome
    output logic      [cdcs_pkg::OUTCOME_BITS-1:0]   m_tuser,
    output logic                                     m_tlast
);

    localparam int IW = (MAX_DELTAS > 2) ? $clog2(MAX_DELTAS) : 1;
    localparam int CW = $clog2(MAX_DELTAS + 1);
    localparam int PW = IW + 1;
    localparam int CB = cdcs_pkg::COST_BITS;
    localparam int VB = VERSION_BITS;
    localparam logic [PW-1:0] PREV_NONE = {PW{1'b1}};
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_DELTAS);

    cdcs_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic [IW-1:0] pidx_reg, pidx_next;
    logic [VB-1:0] target_reg, target_next;
    logic          vfound_reg, vfound_next;
    logic [IW-1:0] v_reg, v_next;
    logic [CB-1:0] bw_reg, bw_next;
    logic [VB-1:0] tgtv_reg, tgtv_next;
    logic [PW-1:0] pv_reg, pv_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] k_reg, k_next;
    logic          m_valid_reg, m_valid_next;
    logic [cdcs_pkg::SLOT_BITS-1:0] slot_reg, slot_next;
    logic [CB-1:0] cost_reg, cost_next;
    logic [cdcs_pkg::OUTCOME_BITS-1:0] outcome_reg, outcome_next;
    logic          last_reg, last_next;

    logic [IW-1:0] stack_mem [MAX_DELTAS];
    logic [IW-1:0] stack_rd_reg;
    logic          stack_we;
    logic [IW-1:0] stack_waddr;
    logic [IW-1:0] stack_raddr;

    logic          tab_we;
    logic [VB-1:0] tab_src, tab_tgt, rd_src, rd_tgt;
    logic [CB-1:0] tab_cost, rd_cost;
    logic          rd_base;
    logic [IW-1:0] rd_addr;
    logic          st_we;
    logic [IW-1:0] st_waddr;
    logic          st_wdone, rd_done;
    logic [PW-1:0] st_wprev, rd_prev;
    logic [CB-1:0] st_wweight, rd_weight;
    logic          issue;
    logic [CB-1:0] relax_w;
    logic [31:0]   from_ext, to_ext;
    logic [55:0]   bytes_ext;

    assign from_ext = 32'(s_tdata[15:0]);
    assign to_ext = 32'(s_tdata[31:16]);
    assign bytes_ext = 56'(s_tdata[71:32]);
    assign tab_src = from_ext[VB-1:0];
    assign tab_tgt = to_ext[VB-1:0];
    assign tab_cost = s_tdata[72] ? '0 : CB'(bytes_ext[SIZE_BITS-1:0]);
    assign tab_we = (state_reg == cdcs_pkg::ST_IDLE) && s_tvalid && s_tuser == cdcs_pkg::CMD_LOAD
                    && count_reg < COUNT_MAX;

    cdcs_table #(.DEPTH(MAX_DELTAS), .IW(IW), .VB(VB), .CB(CB)) u_table (
        .aclk    (aclk),
        .wr_en   (tab_we),
        .wr_addr (count_reg[IW-1:0]),
        .wr_src  (tab_src),
        .wr_tgt  (tab_tgt),
        .wr_cost (tab_cost),
        .wr_base (s_tdata[73]),
        .rd_addr (rd_addr),
        .rd_src  (rd_src),
        .rd_tgt  (rd_tgt),
        .rd_cost (rd_cost),
        .rd_base (rd_base)
    );

    cdcs_state #(.DEPTH(MAX_DELTAS), .IW(IW), .PW(PW), .CB(CB)) u_state (
        .aclk      (aclk),
        .wr_en     (st_we),
        .wr_addr   (st_waddr),
        .wr_done   (st_wdone),
        .wr_prev   (st_wprev),
        .wr_weight (st_wweight),
        .rd_addr   (rd_addr),
        .rd_done   (rd_done),
        .rd_prev   (rd_prev),
        .rd_weight (rd_weight)
    );

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_waddr] <= cur_reg[IW-1:0];
        end
        stack_rd_reg <= stack_mem[stack_raddr];
    end

    assign issue = idx_reg < count_reg;
    assign relax_w = cdcs_pkg::sat_add(bw_reg, rd_cost);
    assign stack_waddr = len_reg[IW-1:0];
    assign stack_raddr = IW'(len_reg - k_reg - CW'(1));

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        pend_next = 1'b0;
        pidx_next = idx_reg[IW-1:0];
        target_next = target_reg;
        vfound_next = vfound_reg;
        v_next = v_reg;
        bw_next = bw_reg;
        tgtv_next = tgtv_reg;
        pv_next = pv_reg;
        cur_next = cur_reg;
        len_next = len_reg;
        k_next = k_reg;
        m_valid_next = m_valid_reg;
        slot_next = slot_reg;
        cost_next = cost_reg;
        outcome_next = outcome_reg;
        last_next = last_reg;
        rd_addr = idx_reg[IW-1:0];
        st_we = 1'b0;
        st_waddr = pidx_reg;
        st_wdone = rd_done;
        st_wprev = rd_prev;
        st_wweight = rd_weight;
        stack_we = 1'b0;
        s_tready = 1'b0;

        unique case (state_reg)
            cdcs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                idx_next = '0;
                if (s_tvalid) begin
                    if (s_tuser == cdcs_pkg::CMD_SEARCH) begin
                        target_next = tab_tgt;
                        state_next = cdcs_pkg::ST_INIT;
                    end else if (tab_we) begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            cdcs_pkg::ST_INIT, cdcs_pkg::ST_SCAN, cdcs_pkg::ST_RELAX,
            cdcs_pkg::ST_FIND: begin
                if (issue) begin
                    idx_next = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    unique case (state_reg)
                        cdcs_pkg::ST_INIT: begin
                            st_we = 1'b1;
                            st_wdone = 1'b0;
                            st_wprev = PREV_NONE;
                            st_wweight = rd_base ? rd_cost : cdcs_pkg::COST_INF;
                        end
                        cdcs_pkg::ST_SCAN: begin
                            if (!rd_done && (!vfound_reg || rd_weight < bw_reg)) begin
                                vfound_next = 1'b1;
                                v_next = pidx_reg;
                                bw_next = rd_weight;
                                tgtv_next = rd_tgt;
                                pv_next = rd_prev;
                            end
                        end
                        cdcs_pkg::ST_RELAX: begin
                            if (rd_src == tgtv_reg && rd_weight > relax_w) begin
                                st_we = 1'b1;
                                st_wprev = PW'(v_reg);
                                st_wweight = relax_w;
                            end
                        end
                        default: begin
                            if (rd_tgt == target_reg && (!vfound_reg || rd_weight < bw_reg)) begin
                                vfound_next = 1'b1;
                                v_next = pidx_reg;
                                bw_next = rd_weight;
                            end
                        end
                    endcase
                end
                if (!issue && !pend_reg) begin
                    idx_next = '0;
                    unique case (state_reg)
                        cdcs_pkg::ST_INIT: begin
                            vfound_next = 1'b0;
                            state_next = cdcs_pkg::ST_SCAN;
                        end
                        cdcs_pkg::ST_SCAN: begin
                            if (!vfound_reg || bw_reg == cdcs_pkg::COST_INF) begin
                                vfound_next = 1'b0;
                                state_next = cdcs_pkg::ST_FIND;
                            end else begin
                                state_next = cdcs_pkg::ST_MARK;
                            end
                        end
                        cdcs_pkg::ST_RELAX: begin
                            vfound_next = 1'b0;
                            state_next = cdcs_pkg::ST_SCAN;
                        end
                        default: begin
                            last_next = 1'b1;
                            cost_next = cdcs_pkg::COST_INF;
                            slot_next = cdcs_pkg::SLOT_BITS'(v_reg);
                            cur_next = PW'(v_reg);
                            len_next = '0;
                            if (!vfound_reg) begin
                                slot_next = '0;
                                outcome_next = cdcs_pkg::OUT_NO_MATCH;
                                m_valid_next = 1'b1;
                                state_next = cdcs_pkg::ST_OUT;
                            end else if (bw_reg == cdcs_pkg::COST_INF) begin
                                outcome_next = cdcs_pkg::OUT_UNREACHABLE;
                                m_valid_next = 1'b1;
                                state_next = cdcs_pkg::ST_OUT;
                            end else begin
                                state_next = cdcs_pkg::ST_WALK_RD;
                            end
                        end
                    endcase
                end
            end
            cdcs_pkg::ST_MARK: begin
                st_we = 1'b1;
                st_waddr = v_reg;
                st_wdone = 1'b1;
                st_wprev = pv_reg;
                st_wweight = bw_reg;
                state_next = cdcs_pkg::ST_RELAX;
            end
            cdcs_pkg::ST_WALK_RD: begin
                rd_addr = cur_reg[IW-1:0];
                if (CW'(cur_reg) < count_reg && cur_reg <= PW'(MAX_DELTAS - 1)
                    && len_reg < COUNT_MAX) begin
                    state_next = cdcs_pkg::ST_WALK_WAIT;
                end else begin
                    k_next = '0;
                    state_next = cdcs_pkg::ST_EMIT_RD;
                end
            end
            cdcs_pkg::ST_WALK_WAIT: begin
                stack_we = 1'b1;
                len_next = len_reg + CW'(1);
                cur_next = rd_prev;
                state_next = cdcs_pkg::ST_WALK_RD;
            end
            cdcs_pkg::ST_EMIT_RD: begin
                state_next = cdcs_pkg::ST_EMIT_LD;
            end
            cdcs_pkg::ST_EMIT_LD: begin
                slot_next = cdcs_pkg::SLOT_BITS'(stack_rd_reg);
                cost_next = bw_reg;
                outcome_next = cdcs_pkg::OUT_FOUND;
                last_next = (k_reg == len_reg - CW'(1));
                m_valid_next = 1'b1;
                state_next = cdcs_pkg::ST_OUT;
            end
            cdcs_pkg::ST_OUT: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    if (last_reg) begin
                        count_next = '0;
                        state_next = cdcs_pkg::ST_IDLE;
                    end else begin
                        k_next = k_reg + CW'(1);
                        state_next = cdcs_pkg::ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = cdcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cdcs_pkg::ST_IDLE;
            count_reg <= '0;
            pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            vfound_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg <= pend_next;
            m_valid_reg <= m_valid_next;
            vfound_reg <= vfound_next;
        end
        idx_reg <= idx_next;
        pidx_reg <= pidx_next;
        target_reg <= target_next;
        v_reg <= v_next;
        bw_reg <= bw_next;
        tgtv_reg <= tgtv_next;
        pv_reg <= pv_next;
        cur_reg <= cur_next;
        len_reg <= len_next;
        k_reg <= k_next;
        slot_reg <= slot_next;
        cost_reg <= cost_next;
        outcome_reg <= outcome_next;
        last_reg <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {3'b000, cost_reg, slot_reg};
    assign m_tuser = outcome_reg;
    assign m_tlast = last_reg;

    `CDCS_ASSERT_NOW(a_no_overlap, s_tready, !m_tvalid, "Input taken while a result is pending.")
    `CDCS_ASSERT_NEXT(a_clear_after, m_tvalid && m_tready && m_tlast, count_reg == '0,
        "Table not cleared after the final result.")
    `CDCS_ASSERT_NOW(a_mark_found, state_reg == cdcs_pkg::ST_MARK,
        vfound_reg && bw_reg != cdcs_pkg::COST_INF, "Settling without a finite candidate.")
    `CDCS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= COUNT_MAX, "Entry count beyond depth.")

endmodule

`default_nettype wire
